// File: hw/rtl/bpa_pkg.sv
// bpa_pkg: widths, fixed-point constants, word flags and ROM builders for the
// barometric altitude pipeline. No dependencies.
`default_nettype none
package bpa_pkg;

  localparam int P_W   = 23;
  localparam int VP_W  = 32;
  localparam int ALT_W = 22;
  localparam int VAR_W = 32;
  localparam int LG_W  = 32;

  localparam int DIV_Q_W  = 32;
  localparam int DIV_STEP = 4;

  localparam logic signed [32:0] LOG2_P0_Q24 = 33'sd278982128;
  localparam logic [21:0]        N_Q24       = 22'd3191867;
  localparam logic [30:0]        S_Q8        = 31'd1134867692;
  localparam logic [29:0]        K_Q16       = 30'd552726233;
  localparam logic [29:0]        EARTH_R_CM  = 30'd635676600;
  localparam logic signed [27:0] TROPO_CM    = 28'sd1100000;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [21:0] ALT_MIN_CM  = -22'sd200000;
  localparam logic signed [21:0] ALT_MAX_CM  = 22'sd1200000;

  typedef struct packed {
    logic neg;
    logic sat;
    logic ovf;
  } flg_t;

  function automatic longint unsigned isqrt(input longint unsigned n_in);
    longint unsigned n;
    longint unsigned res;
    longint unsigned bit_v;
    n = n_in;
    res = 64'd0;
    bit_v = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bit_v > n) bit_v = bit_v >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_v != 64'd0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^tbits) in Q24, one bit per squaring
  function automatic logic [24:0] log_entry(input int tbits, input int idx);
    longint unsigned x;
    logic [24:0] acc;
    if (idx >= (1 << tbits)) return 25'd16777216;
    x = 64'((1 << tbits) + idx) << (30 - tbits);
    acc = '0;
    for (int b = 23; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  // 2^(i/2^tbits) in Q30 from repeated floor square roots of 2
  function automatic logic [31:0] exp_entry(input int tbits, input int idx);
    longint unsigned roots [13];
    longint unsigned v;
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= 12; j++) begin
      roots[j] = (j <= tbits) ? isqrt(roots[j-1] << 30) : 64'd0;
    end
    if (idx >= (1 << tbits)) return 32'(roots[0]);
    v = 64'd1 << 30;
    for (int b = 0; b < 12; b++) begin
      if (b < tbits && ((idx >> b) & 1) == 1) v = (v * roots[tbits-b]) >> 30;
    end
    return 32'(v);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bpa_log.sv
// bpa_log: two-stage log2 of the pressure word (leading-one normalize, ROM
// lookup, linear interpolation). Depends on bpa_pkg.
`default_nettype none
module bpa_log #(
  parameter int POW_TABLE_BITS     = 8,
  parameter int PRESSURE_FRAC_BITS = 6
) (
  input  logic                            clk,
  input  logic                            en_i,
  input  logic [bpa_pkg::P_W-1:0]         p_i,
  output logic signed [bpa_pkg::LG_W-1:0] lg_o
);
  import bpa_pkg::*;

  localparam int TN = 1 << POW_TABLE_BITS;
  localparam int SH = 24 - POW_TABLE_BITS;

  logic [24:0] tab [TN+1];
  for (genvar i = 0; i <= TN; i++) begin : g_tab
    localparam logic [24:0] ENT = log_entry(POW_TABLE_BITS, i);
    assign tab[i] = ENT;
  end

  logic [4:0]                msb;
  logic [P_W-1:0]            norm;
  logic [23:0]               f24;
  logic [POW_TABLE_BITS-1:0] idx;

  logic [4:0]    msb_r;
  logic [24:0]   t0_r;
  logic [24:0]   dlt_r;
  logic [SH-1:0] rem_r;

  always_comb begin
    msb = '0;
    for (int b = 0; b < P_W; b++) begin
      if (p_i[b]) msb = 5'(b);
    end
    norm = p_i << (5'(P_W - 1) - msb);
    f24  = {norm[P_W-2:0], 2'b00};
    idx  = f24[23 -: POW_TABLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      msb_r <= msb;
      t0_r  <= tab[{1'b0, idx}];
      dlt_r <= tab[{1'b0, idx} + 1'b1] - tab[{1'b0, idx}];
      rem_r <= f24[SH-1:0];
    end
  end

  logic signed [6:0]      ex;
  logic [25+SH-1:0]       prod;
  logic signed [LG_W-1:0] lg;
  logic signed [LG_W-1:0] lg_r;

  always_comb begin
    ex   = signed'({2'b00, msb_r}) - 7'(PRESSURE_FRAC_BITS);
    prod = dlt_r * rem_r;
    lg   = LG_W'(signed'({ex, 24'd0})) + LG_W'(prod >> SH) + LG_W'(t0_r);
  end

  always_ff @(posedge clk) begin
    if (en_i) lg_r <= lg;
  end

  assign lg_o = lg_r;

endmodule
`default_nettype wire

// File: hw/rtl/bpa_pow.sv
// bpa_pow: three-stage pressure ratio power, y = n*(log2 p - log2 p0) then
// r = 2^y in Q30 via exp2 ROM and interpolation. Depends on bpa_pkg.
`default_nettype none
module bpa_pow #(
  parameter int POW_TABLE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            en_i,
  input  logic signed [bpa_pkg::LG_W-1:0] lg_i,
  output logic [32:0]                     r_o
);
  import bpa_pkg::*;

  localparam int TN = 1 << POW_TABLE_BITS;
  localparam int SH = 24 - POW_TABLE_BITS;

  logic [31:0] tab [TN+1];
  for (genvar i = 0; i <= TN; i++) begin : g_tab
    localparam logic [31:0] ENT = exp_entry(POW_TABLE_BITS, i);
    assign tab[i] = ENT;
  end

  // scale by exponent n
  logic signed [LG_W:0] d;
  logic signed [55:0]   prod_y;
  logic signed [31:0]   y_r;

  always_comb begin
    d      = (LG_W+1)'(lg_i) - LOG2_P0_Q24;
    prod_y = d * signed'({1'b0, N_Q24});
  end

  always_ff @(posedge clk) begin
    if (en_i) y_r <= prod_y[55:24];
  end

  // exp2 lookup
  logic [POW_TABLE_BITS-1:0] idx;
  logic signed [7:0]         k_r;
  logic [31:0]               t0_r;
  logic [31:0]               dlt_r;
  logic [SH-1:0]             rem_r;

  assign idx = y_r[23 -: POW_TABLE_BITS];

  always_ff @(posedge clk) begin
    if (en_i) begin
      k_r   <= y_r[31:24];
      t0_r  <= tab[{1'b0, idx}];
      dlt_r <= tab[{1'b0, idx} + 1'b1] - tab[{1'b0, idx}];
      rem_r <= y_r[SH-1:0];
    end
  end

  // interpolate and apply integer exponent; a positive exponent only doubles the mantissa
  logic [32+SH-1:0] prod;
  logic [31:0]      mant;
  logic [7:0]       nsh;
  logic [32:0]      r;
  logic [32:0]      r_r;

  always_comb begin
    prod = dlt_r * rem_r;
    mant = t0_r + 32'(prod >> SH);
    nsh  = 8'(-k_r);
    if (k_r > 8'sd0) begin
      r = {mant, 1'b0};
    end else if (k_r == 8'sd0) begin
      r = {1'b0, mant};
    end else if (nsh >= 8'd32) begin
      r = '0;
    end else begin
      r = {1'b0, mant >> nsh[4:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) r_r <= r;
  end

  assign r_o = r_r;

endmodule
`default_nettype wire

// File: hw/rtl/bpa_div.sv
// bpa_div: pipelined restoring divider, STEP_N quotient bits per stage.
// Quotient must fit in Q_W bits. Depends on bpa_pkg.
`default_nettype none
module bpa_div #(
  parameter int NUM_W  = 58,
  parameter int DEN_W  = 30,
  parameter int Q_W    = 32,
  parameter int STEP_N = 4
) (
  input  logic             clk,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);
  import bpa_pkg::*;

  localparam int NST = Q_W / STEP_N;
  localparam int RW  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem_r [NST-1];
  logic [DEN_W-1:0] den_r [NST-1];
  logic [Q_W-1:0]   quo_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stg
    logic [RW-1:0]    rem_a;
    logic [RW-1:0]    rem_c;
    logic [DEN_W-1:0] den_a;
    logic [Q_W-1:0]   quo_a;
    logic [Q_W-1:0]   quo_c;

    if (s == 0) begin : g_head
      assign rem_a = RW'(num_i);
      assign den_a = den_i;
      assign quo_a = '0;
    end else begin : g_body
      assign rem_a = rem_r[s-1];
      assign den_a = den_r[s-1];
      assign quo_a = quo_r[s-1];
    end

    always_comb begin
      logic [RW-1:0] shd;
      rem_c = rem_a;
      quo_c = quo_a;
      for (int j = 0; j < STEP_N; j++) begin
        shd = RW'(den_a) << (Q_W - 1 - s*STEP_N - j);
        if (rem_c >= shd) begin
          rem_c = rem_c - shd;
          quo_c[Q_W-1-s*STEP_N-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) quo_r[s] <= quo_c;
    end

    if (s < NST - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en_i) begin
          rem_r[s] <= rem_c;
          den_r[s] <= den_a;
        end
      end
    end
  end

  assign quo_o = quo_r[NST-1];

endmodule
`default_nettype wire

// File: hw/rtl/barometric_pressure_to_altitude.sv
// Barometric altimeter top level: ISA troposphere pressure to geometric altitude
// with variance. Depends on bpa_pkg, bpa_log, bpa_pow, bpa_div.
//
// Usage:
//   Input word: in_pressure_q6 (Pa, unsigned fixed point) and
//   in_pressure_variance_q8, taken when in_valid and in_ready are high.
//   Output word: out_altitude_cm, out_altitude_variance_q8, out_out_of_range,
//   taken when out_valid and out_ready are high. One output word per input.
//   Register stages: 2 log2, 3 power, 2 height/slope, 8 divider
//   (32 quotient bits at 4 per stage), 3 clamp/square/scale.
//   Throughput is one word per cycle while the pipe does not hold; each
//   register stage has its own valid bit; both dividers are fully pipelined.
//   Zero pressure or height at/above 11 km gives out_of_range with
//   saturated outputs.
//   Reset (rst_n low, synchronous) clears all valid bits; no words in flight.
//   When the output register holds a word and out_ready is low, the whole
//   pipe holds and in_ready drops; nothing is lost or repeated.
`default_nettype none
module barometric_pressure_to_altitude #(
  parameter int POW_TABLE_BITS     = 8,
  parameter int PRESSURE_FRAC_BITS = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bpa_pkg::P_W-1:0]          in_pressure_q6,
  input  logic [bpa_pkg::VP_W-1:0]         in_pressure_variance_q8,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bpa_pkg::ALT_W-1:0] out_altitude_cm,
  output logic [bpa_pkg::VAR_W-1:0]        out_altitude_variance_q8,
  output logic                             out_out_of_range
);
  import bpa_pkg::*;

  localparam int DIV_NST = DIV_Q_W / DIV_STEP;
  localparam int P_SH    = 14 - PRESSURE_FRAC_BITS;
  localparam int DB_W    = P_W + P_SH;
  localparam int NA_W    = 58;
  localparam int NB_W    = 63;
  localparam int CMP_W   = (NB_W > DB_W + DIV_Q_W) ? NB_W : DB_W + DIV_Q_W;
  localparam int LAT     = 7 + DIV_NST + 3;
  localparam int P_DLY   = 6;
  localparam int F_DLY   = DIV_NST + 1;
  localparam int V_DLY   = LAT - 1;

  logic en;
  logic vld_r [LAT];

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // sideband lines
  logic [P_W-1:0]  p_d  [P_DLY];
  logic [VP_W-1:0] vp_d [V_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      p_d[0]  <= in_pressure_q6;
      vp_d[0] <= in_pressure_variance_q8;
      for (int i = 1; i < P_DLY; i++) p_d[i] <= p_d[i-1];
      for (int i = 1; i < V_DLY; i++) vp_d[i] <= vp_d[i-1];
    end
  end

  logic signed [LG_W-1:0] lg;
  logic [32:0]            r;

  bpa_log #(
    .POW_TABLE_BITS    (POW_TABLE_BITS),
    .PRESSURE_FRAC_BITS(PRESSURE_FRAC_BITS)
  ) u_log (
    .clk (clk),
    .en_i(en),
    .p_i (in_pressure_q6),
    .lg_o(lg)
  );

  bpa_pow #(
    .POW_TABLE_BITS(POW_TABLE_BITS)
  ) u_pow (
    .clk (clk),
    .en_i(en),
    .lg_i(lg),
    .r_o (r)
  );

  // geopotential height and slope numerator
  logic signed [33:0] rdiff;
  logic signed [65:0] gprod;
  logic [NB_W-1:0]    x_nxt;
  logic signed [27:0] g_r;
  logic [NB_W-1:0]    x_r;

  always_comb begin
    rdiff = ONE_Q30 - signed'({1'b0, r});
    gprod = rdiff * signed'({1'b0, S_Q8});
    x_nxt = K_Q16 * r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= gprod[65:38];
      x_r <= x_nxt;
    end
  end

  // range check and divider operands
  flg_t               fl_nxt;
  logic [27:0]        absg;
  logic signed [30:0] dena_s;
  logic [NA_W-1:0]    numa_nxt;
  logic [29:0]        dena_nxt;
  logic [DB_W-1:0]    denb_nxt;
  logic [NA_W-1:0]    numa_r;
  logic [29:0]        dena_r;
  logic [DB_W-1:0]    denb_r;
  logic [NB_W-1:0]    numb_r;
  flg_t               fl_d [F_DLY];

  always_comb begin
    fl_nxt.neg = g_r[27];
    fl_nxt.sat = (p_d[P_DLY-1] == '0) || (g_r >= TROPO_CM);
    absg       = g_r[27] ? 28'(-g_r) : 28'(g_r);
    numa_nxt   = fl_nxt.sat ? '0 : EARTH_R_CM * absg;
    dena_s     = signed'({1'b0, EARTH_R_CM}) - 31'(g_r);
    dena_nxt   = fl_nxt.sat ? EARTH_R_CM : dena_s[29:0];
    denb_nxt   = DB_W'(p_d[P_DLY-1]) << P_SH;
    fl_nxt.ovf = CMP_W'(x_r) >= (CMP_W'(denb_nxt) << DIV_Q_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numa_r   <= numa_nxt;
      dena_r   <= dena_nxt;
      numb_r   <= x_r;
      denb_r   <= denb_nxt;
      fl_d[0]  <= fl_nxt;
      for (int i = 1; i < F_DLY; i++) fl_d[i] <= fl_d[i-1];
    end
  end

  logic [DIV_Q_W-1:0] qa;
  logic [DIV_Q_W-1:0] qb;

  bpa_div #(
    .NUM_W (NA_W),
    .DEN_W (30),
    .Q_W   (DIV_Q_W),
    .STEP_N(DIV_STEP)
  ) u_div_alt (
    .clk  (clk),
    .en_i (en),
    .num_i(numa_r),
    .den_i(dena_r),
    .quo_o(qa)
  );

  bpa_div #(
    .NUM_W (NB_W),
    .DEN_W (DB_W),
    .Q_W   (DIV_Q_W),
    .STEP_N(DIV_STEP)
  ) u_div_slope (
    .clk  (clk),
    .en_i (en),
    .num_i(numb_r),
    .den_i(denb_r),
    .quo_o(qb)
  );

  // altitude clamp and slope saturation
  logic signed [33:0]      hs;
  logic signed [ALT_W-1:0] h_nxt;
  logic [31:0]             amp_nxt;
  logic signed [ALT_W-1:0] h1_r;
  logic [31:0]             amp_r;
  logic                    sat1_r;

  always_comb begin
    hs = fl_d[F_DLY-1].neg ? -signed'({2'b00, qa}) : signed'({2'b00, qa});
    if (fl_d[F_DLY-1].sat) begin
      h_nxt = ALT_MAX_CM;
    end else if (hs < 34'(ALT_MIN_CM)) begin
      h_nxt = ALT_MIN_CM;
    end else if (hs > 34'(ALT_MAX_CM)) begin
      h_nxt = ALT_MAX_CM;
    end else begin
      h_nxt = hs[ALT_W-1:0];
    end
    amp_nxt = fl_d[F_DLY-1].ovf ? '1 : qb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r   <= h_nxt;
      amp_r  <= amp_nxt;
      sat1_r <= fl_d[F_DLY-1].sat;
    end
  end

  // slope squared
  logic [63:0]             sq;
  logic signed [ALT_W-1:0] h2_r;
  logic [31:0]             a2_r;
  logic                    sat2_r;

  assign sq = amp_r * amp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h2_r   <= h1_r;
      a2_r   <= sq[63:32];
      sat2_r <= sat1_r;
    end
  end

  // variance scale and output register
  logic [63:0] vprod;

  assign vprod = a2_r * vp_d[V_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_altitude_cm          <= h2_r;
      out_altitude_variance_q8 <= sat2_r ? '1 : vprod[63:32];
      out_out_of_range         <= sat2_r;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bpa_chk.sv
// bpa_chk: port-level assertions for the barometric altimeter, bound to the
// top level. Depends on bpa_pkg and barometric_pressure_to_altitude.
`default_nettype none
module bpa_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [bpa_pkg::P_W-1:0]          in_pressure_q6,
  input logic [bpa_pkg::VP_W-1:0]         in_pressure_variance_q8,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [bpa_pkg::ALT_W-1:0] out_altitude_cm,
  input logic [bpa_pkg::VAR_W-1:0]        out_altitude_variance_q8,
  input logic                             out_out_of_range
);
  import bpa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_altitude_cm) &&
      $stable(out_altitude_variance_q8) && $stable(out_out_of_range))
    else $error("output word changed while stalled");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_altitude_cm == ALT_MAX_CM && out_altitude_variance_q8 == '1)
    else $error("out of range word not saturated");

  a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_altitude_cm >= ALT_MIN_CM && out_altitude_cm < 22'sd1100000 + 22'sd10000)
    else $error("altitude outside clamp range");

endmodule

bind barometric_pressure_to_altitude bpa_chk u_bpa_chk (.*);
`default_nettype wire
